### hw/rtl/fees_pkg.sv
// ----------------------------------------------------------------------------
// fees_pkg
// Types and codes shared by the two-page record store.
// ----------------------------------------------------------------------------
package fees_pkg;

   typedef enum logic [1:0] {
      REQ_READ   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_FORMAT = 2'd2,
      REQ_INIT   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_BAD_KEY   = 2'd2,
      STS_NO_PAGE   = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      PG_ERASED  = 2'd0,
      PG_RECEIVE = 2'd1,
      PG_VALID   = 2'd2,
      PG_UNUSED  = 2'd3
   } page_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_NEXT_KEY,
      ST_SCAN,
      ST_SCAN_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] key;
      logic [31:0] write_data;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic        compacted;
   } rsp_data_type;

   typedef struct packed {
      logic [15:0] key;
      logic [31:0] value;
   } slot_type;

endpackage

### hw/rtl/flash_eeprom_emulation_store_top.sv
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_store_top
// Two-page key/value record store with append, lookup and compaction.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// response appears on rsp_data for one cycle with rsp_valid, and the
// receiver must take it then. Format, init without repair, bad-key,
// no-page and write-with-room transactions answer from the decode state.
// A read scans the valid page one slot per cycle through the single slot
// memory read port. A compaction (write to a full page, or init repairing a
// receive page) scans the source page once per key 1..MAX_KEYS other than
// the key being written. No clearing pass follows reset: per-page fill
// counts mark which slots hold records.
// ----------------------------------------------------------------------------
module flash_eeprom_emulation_store_top #(
   parameter int SLOTS_PER_PAGE = 256,
   parameter int MAX_KEYS       = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fees_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   output fees_pkg::rsp_data_type rsp_data
);
   import fees_pkg::*;

   localparam int DEPTH = 2 * SLOTS_PER_PAGE;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = $clog2(SLOTS_PER_PAGE + 1);
   localparam int KW    = $clog2(MAX_KEYS + 2);

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   fsm_state_type  state_ff, state_in;
   req_data_type   req_ff, req_in;
   logic           src_ff, src_in, dst_ff, dst_in;
   logic           mode_read_ff, mode_read_in;
   logic [15:0]    new_key_ff, new_key_in;
   logic           comp_ff, comp_in;
   logic [KW-1:0]  cur_key_ff, cur_key_in;
   logic [FW-1:0]  idx_ff, idx_in;
   logic           pend_ff, pend_in;
   logic           hit_ff, hit_in;
   logic [31:0]    val_ff, val_in;
   page_state_type pstate_ff [2];
   page_state_type pstate_in [2];
   logic [FW-1:0]  fill_ff [2];
   logic [FW-1:0]  fill_in [2];
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_data_type   rsp_ff, rsp_in;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   slot_type       mem_wdata;

   logic           act_ok, act_pg, key_bad, issue;
   logic [15:0]    scan_key;

   function automatic logic [AW-1:0] slot_addr(input logic pg, input logic [FW-1:0] i);
      logic [AW-1:0] base;
      base = pg ? AW'(SLOTS_PER_PAGE) : '0;
      return base + AW'(i);
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign act_ok   = (pstate_ff[0] == PG_VALID) || (pstate_ff[1] == PG_VALID);
   assign act_pg   = (pstate_ff[0] != PG_VALID);
   assign key_bad  = (req_ff.key == 16'd0) || (req_ff.key > 16'(MAX_KEYS));
   assign scan_key = mode_read_ff ? req_ff.key : 16'(cur_key_ff);
   assign issue    = (state_ff == ST_SCAN) && (idx_ff < fill_ff[src_ff]);
   assign mem_raddr = slot_addr(src_ff, idx_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pstate_ff[0] <= PG_ERASED;
         pstate_ff[1] <= PG_ERASED;
         fill_ff[0]   <= '0;
         fill_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pstate_ff    <= pstate_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      req_ff       <= req_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      mode_read_ff <= mode_read_in;
      new_key_ff   <= new_key_in;
      comp_ff      <= comp_in;
      cur_key_ff   <= cur_key_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      val_ff       <= val_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      mode_read_in = mode_read_ff;
      new_key_in   = new_key_ff;
      comp_in      = comp_ff;
      cur_key_in   = cur_key_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      val_in       = val_ff;
      pstate_in    = pstate_ff;
      fill_in      = fill_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            rsp_in       = '0;
            rsp_in.status = STS_OK;
            mode_read_in = 1'b0;
            new_key_in   = '0;
            comp_in      = 1'b0;
            cur_key_in   = KW'(1);
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (req_code_type'(req_ff.req_type))
               REQ_READ, REQ_WRITE: begin
                  if (key_bad) begin
                     rsp_in.status = STS_BAD_KEY;
                  end else if (!act_ok) begin
                     rsp_in.status = STS_NO_PAGE;
                  end else if (req_ff.req_type == REQ_READ) begin
                     mode_read_in = 1'b1;
                     src_in       = act_pg;
                     idx_in       = '0;
                     hit_in       = 1'b0;
                     state_in     = ST_SCAN;
                     rsp_valid_in = 1'b0;
                  end else if (fill_ff[act_pg] < FW'(SLOTS_PER_PAGE)) begin
                     mem_we          = 1'b1;
                     mem_waddr       = slot_addr(act_pg, fill_ff[act_pg]);
                     mem_wdata.key   = req_ff.key;
                     mem_wdata.value = req_ff.write_data;
                     fill_in[act_pg] = fill_ff[act_pg] + FW'(1);
                  end else begin
                     src_in           = act_pg;
                     dst_in           = !act_pg;
                     new_key_in       = req_ff.key;
                     comp_in          = 1'b1;
                     fill_in[!act_pg] = '0;
                     pstate_in[!act_pg] = PG_RECEIVE;
                     state_in         = ST_NEXT_KEY;
                     rsp_valid_in     = 1'b0;
                  end
               end
               REQ_FORMAT: begin
                  fill_in[0]   = '0;
                  fill_in[1]   = '0;
                  pstate_in[0] = PG_VALID;
                  pstate_in[1] = PG_ERASED;
               end
               REQ_INIT: begin
                  priority if ((pstate_ff[0] == PG_VALID && pstate_ff[1] == PG_ERASED) ||
                               (pstate_ff[1] == PG_VALID && pstate_ff[0] == PG_ERASED)) begin
                     rsp_in.status = STS_OK;
                  end else if (pstate_ff[0] == PG_VALID && pstate_ff[1] == PG_VALID) begin
                     fill_in[1]   = '0;
                     pstate_in[1] = PG_ERASED;
                  end else if (pstate_ff[0] == PG_RECEIVE && pstate_ff[1] == PG_VALID) begin
                     src_in       = 1'b1;
                     dst_in       = 1'b0;
                     fill_in[0]   = '0;
                     pstate_in[0] = PG_RECEIVE;
                     state_in     = ST_NEXT_KEY;
                     rsp_valid_in = 1'b0;
                  end else if (pstate_ff[0] != PG_RECEIVE && pstate_ff[1] == PG_RECEIVE &&
                               pstate_ff[0] == PG_VALID) begin
                     src_in       = 1'b0;
                     dst_in       = 1'b1;
                     fill_in[1]   = '0;
                     pstate_in[1] = PG_RECEIVE;
                     state_in     = ST_NEXT_KEY;
                     rsp_valid_in = 1'b0;
                  end else begin
                     fill_in[0]   = '0;
                     fill_in[1]   = '0;
                     pstate_in[0] = PG_VALID;
                     pstate_in[1] = PG_ERASED;
                  end
               end
               default: begin
                  rsp_in.status = STS_OK;
               end
            endcase
         end

         ST_NEXT_KEY: begin
            if (cur_key_ff > KW'(MAX_KEYS)) begin
               if (new_key_ff != 16'd0 && fill_ff[dst_ff] < FW'(SLOTS_PER_PAGE)) begin
                  mem_we          = 1'b1;
                  mem_waddr       = slot_addr(dst_ff, fill_ff[dst_ff]);
                  mem_wdata.key   = new_key_ff;
                  mem_wdata.value = req_ff.write_data;
                  fill_in[dst_ff] = fill_ff[dst_ff] + FW'(1);
               end
               pstate_in[dst_ff] = PG_VALID;
               pstate_in[src_ff] = PG_ERASED;
               fill_in[src_ff]   = '0;
               rsp_in            = '0;
               rsp_in.status     = STS_OK;
               rsp_in.compacted  = comp_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end else if (16'(cur_key_ff) == new_key_ff) begin
               cur_key_in = cur_key_ff + KW'(1);
            end else begin
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (issue) begin
               idx_in  = idx_ff + FW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && rd_data_ff.key == scan_key) begin
               hit_in = 1'b1;
               val_in = rd_data_ff.value;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_SCAN_DONE;
            end
         end

         ST_SCAN_DONE: begin
            if (mode_read_ff) begin
               rsp_in            = '0;
               rsp_in.status     = hit_ff ? STS_OK : STS_NOT_FOUND;
               rsp_in.read_value = hit_ff ? val_ff : 32'd0;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               if (hit_ff && fill_ff[dst_ff] < FW'(SLOTS_PER_PAGE)) begin
                  mem_we          = 1'b1;
                  mem_waddr       = slot_addr(dst_ff, fill_ff[dst_ff]);
                  mem_wdata.key   = 16'(cur_key_ff);
                  mem_wdata.value = val_ff;
                  fill_in[dst_ff] = fill_ff[dst_ff] + FW'(1);
               end
               cur_key_in = cur_key_ff + KW'(1);
               state_in   = ST_NEXT_KEY;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### verif/flash_eeprom_emulation_store_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_store_top_tb
// Drives read, write, format and init transactions into the two-page record
// store, tracks page contents in a scoreboard model and checks every
// response field by field, including writes that force a page compaction.
// ----------------------------------------------------------------------------
module flash_eeprom_emulation_store_top_tb;
   import fees_pkg::*;

   localparam int SLOTS     = 256;
   localparam int MAXK      = 64;
   localparam int NUM_RAND  = 1750;
   localparam int MAX_CYCLE = 4000000;
   localparam logic [15:0] EMPTY_KEY = 16'hFFFF;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_data_type  req_data = '0;
   logic          rsp_valid;
   rsp_data_type  rsp_data;
   int unsigned   cycle_cnt = 0;

   flash_eeprom_emulation_store_top #(
      .SLOTS_PER_PAGE(SLOTS),
      .MAX_KEYS      (MAXK)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   class record_store_scoreboard;
      logic [15:0]    keys[2][SLOTS];
      logic [31:0]    vals[2][SLOTS];
      page_state_type pstate[2];
      int             fill[2];
      rsp_data_type   expected_rsp[$];
      int             errors;

      function new();
         errors = 0;
         for (int p = 0; p < 2; p++) erase_page(p);
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void erase_page(int p);
         for (int i = 0; i < SLOTS; i++) keys[p][i] = EMPTY_KEY;
         pstate[p] = PG_ERASED;
         fill[p] = 0;
      endfunction

      function int valid_page();
         if (pstate[0] == PG_VALID) return 0;
         if (pstate[1] == PG_VALID) return 1;
         return 2;
      endfunction

      function bit find_latest(int p, logic [15:0] k, output logic [31:0] v);
         bit hit;
         hit = 0;
         v = '0;
         for (int i = 0; i < SLOTS; i++) begin
            if (keys[p][i] == EMPTY_KEY) break;
            if (keys[p][i] == k) begin
               v = vals[p][i];
               hit = 1;
            end
         end
         return hit;
      endfunction

      function void append(int p, logic [15:0] k, logic [31:0] v);
         if (fill[p] >= SLOTS) return;
         keys[p][fill[p]] = k;
         vals[p][fill[p]] = v;
         fill[p]++;
      endfunction

      // new key 0: copy only
      function void compact(logic [15:0] nk, logic [31:0] nv);
         int src, dst;
         logic [31:0] v;
         src = valid_page();
         if (src > 1) return;
         dst = src ^ 1;
         erase_page(dst);
         pstate[dst] = PG_RECEIVE;
         for (int k = 1; k <= MAXK; k++) begin
            if (k == nk) continue;
            if (find_latest(src, k[15:0], v)) append(dst, k[15:0], v);
         end
         if (nk != 0) append(dst, nk, nv);
         pstate[dst] = PG_VALID;
         erase_page(src);
      endfunction

      function void format_pages();
         erase_page(0);
         erase_page(1);
         pstate[0] = PG_VALID;
      endfunction

      function void init_check();
         page_state_type s0, s1;
         s0 = pstate[0];
         s1 = pstate[1];
         if (s0 == PG_VALID && s1 == PG_ERASED) return;
         if (s1 == PG_VALID && s0 == PG_ERASED) return;
         if (s0 == PG_VALID && s1 == PG_VALID) begin
            erase_page(1);
            return;
         end
         if (s0 == PG_RECEIVE) begin
            if (s1 == PG_VALID) begin
               erase_page(0);
               compact(0, 0);
            end else format_pages();
            return;
         end
         if (s1 == PG_RECEIVE) begin
            if (s0 == PG_VALID) begin
               erase_page(1);
               compact(0, 0);
            end else format_pages();
            return;
         end
         format_pages();
      endfunction

      function void note_request(req_data_type r);
         rsp_data_type e;
         int a;
         logic [31:0] v;
         e = '0;
         e.status = STS_OK;
         case (req_code_type'(r.req_type))
            REQ_READ, REQ_WRITE: begin
               a = valid_page();
               if (r.key == 0 || r.key > MAXK) e.status = STS_BAD_KEY;
               else if (a > 1) e.status = STS_NO_PAGE;
               else if (r.req_type == REQ_READ) begin
                  if (find_latest(a, r.key, v)) e.read_value = v;
                  else e.status = STS_NOT_FOUND;
               end else if (fill[a] < SLOTS) append(a, r.key, r.write_data);
               else begin
                  compact(r.key, r.write_data);
                  e.compacted = 1'b1;
               end
            end
            REQ_FORMAT: format_pages();
            default: init_check();
         endcase
         expected_rsp.push_back(e);
      endfunction

      task check_response(rsp_data_type got);
         rsp_data_type e;
         if (expected_rsp.size() == 0) begin
            report($sformatf("unexpected response %h", got));
            return;
         end
         e = expected_rsp.pop_front();
         if (got.status !== e.status)
            report($sformatf("status %0d, want %0d", got.status, e.status));
         if (got.read_value !== e.read_value)
            report($sformatf("read_value %h, want %h", got.read_value, e.read_value));
         if (got.compacted !== e.compacted)
            report($sformatf("compacted %b, want %b", got.compacted, e.compacted));
      endtask
   endclass

   record_store_scoreboard sb = new();
   int sender_idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (!reset && rsp_valid) sb.check_response(rsp_data);
      if (cycle_cnt > MAX_CYCLE) begin
         $display("status: fail");
         $finish;
      end
   end

   // hold start high across back-to-back transactions
   task send(req_code_type t, logic [15:0] k, logic [31:0] d);
      req_data_type r;
      r.req_type   = t;
      r.key        = k;
      r.write_data = d;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task send_random();
      int r;
      logic [15:0] k;
      r = $urandom_range(0, 999);
      if ($urandom_range(0, 99) < 6)
         k = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(MAXK + 1, 65535));
      else if ($urandom_range(0, 3) == 0) k = 16'($urandom_range(1, 4));
      else k = 16'($urandom_range(1, MAXK));
      if (r < 3) send(REQ_FORMAT, k, $urandom);
      else if (r < 20) send(REQ_INIT, k, $urandom);
      else if (r < 600) send(REQ_WRITE, k, $urandom);
      else send(REQ_READ, k, $urandom);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(REQ_READ,   16'd1,          32'h0);
      send(REQ_WRITE,  16'd1,          32'hFFFF_FFFF);
      send(REQ_READ,   16'd0,          32'h0);
      send(REQ_WRITE,  16'hFFFF,       32'h1);
      send(REQ_READ,   16'(MAXK + 1),  32'h0);
      send(REQ_INIT,   16'd0,          32'h0);
      send(REQ_WRITE,  16'd1,          32'hFFFF_FFFF);
      send(REQ_WRITE,  16'(MAXK),      32'h0);
      send(REQ_READ,   16'd1,          32'h0);
      send(REQ_READ,   16'(MAXK),      32'h0);
      send(REQ_READ,   16'd2,          32'h0);
      send(REQ_WRITE,  16'd1,          32'hA5A5_5A5A);
      send(REQ_READ,   16'd1,          32'h0);
      send(REQ_WRITE,  16'(MAXK + 1),  32'h5);
      send(REQ_INIT,   16'hFFFF,       32'hFFFF_FFFF);
      send(REQ_FORMAT, 16'd7,          32'h0);
      send(REQ_READ,   16'd1,          32'h0);
      send(REQ_WRITE,  16'd3,          32'h1234_5678);
      send(REQ_READ,   16'd3,          32'h0);

      sender_idle_pct = 35;
      for (int i = 0; i < NUM_RAND / 3; i++) send_random();
      sender_idle_pct = 80;
      for (int i = 0; i < NUM_RAND / 3; i++) send_random();
      sender_idle_pct = 0;
      for (int i = 0; i < NUM_RAND - 2 * (NUM_RAND / 3); i++) send_random();
      start <= 1'b0;

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
